// File: design/iir_direct_form_one_filter_assert.svh
// assertion macros used by the checker file
`ifndef IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH
`define IIR_DIRECT_FORM_ONE_FILTER_ASSERT_SVH

// clocked check, masked while reset is held
`define IIRDF1_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also looks at the reset cycles
`define IIRDF1_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: design/iirdf1_pkg.sv
package iirdf1_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int HIST_W   = 24;
    localparam int OPND_W   = 24;
    localparam int PROD_W   = COEF_W + OPND_W;
    localparam int ACC_W    = PROD_W + 4;
    localparam int X_SHIFT  = OPND_W - SAMPLE_W;
    localparam int SHIFT_H  = 14;
    localparam int SHIFT_Y  = 22;
    localparam int TAPS_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [TAPS_W-1:0]        TAPS_RESET = 2'd3;
    localparam logic signed [COEF_W-1:0] B0_RESET   = 18'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FF,
        ST_FB,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic sel_fb;
        logic round;
    } t_seq_ctl;

endpackage

// File: design/iirdf1_mac.sv
module iirdf1_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  logic                                   i_issue,
    input  logic                                   i_sub,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]   i_coef,
    input  logic signed [iirdf1_pkg::OPND_W-1:0]   i_opnd,
    output logic signed [iirdf1_pkg::ACC_W-1:0]    o_acc
);

    logic signed [iirdf1_pkg::PROD_W-1:0] r_prod;
    logic                                 r_prod_vld;
    logic                                 r_prod_sub;
    logic signed [iirdf1_pkg::ACC_W-1:0]  r_acc;
    logic signed [iirdf1_pkg::ACC_W-1:0]  w_prod_ext;

    assign w_prod_ext = iirdf1_pkg::ACC_W'(r_prod);

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_issue;
        end
        r_prod     <= i_coef * i_opnd;
        r_prod_sub <= i_sub;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? r_acc - w_prod_ext : r_acc + w_prod_ext;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: design/iirdf1_round.sv
module iirdf1_round (
    input  logic signed [iirdf1_pkg::ACC_W-1:0]    i_acc,
    output logic signed [iirdf1_pkg::HIST_W-1:0]   o_hist,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int AW = iirdf1_pkg::ACC_W;
    localparam logic signed [AW-1:0] HALF_H = AW'(1) << (iirdf1_pkg::SHIFT_H - 1);
    localparam logic signed [AW-1:0] HALF_Y = AW'(1) << (iirdf1_pkg::SHIFT_Y - 1);
    localparam logic signed [AW-1:0] HMAX = (AW'(1) << (iirdf1_pkg::HIST_W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] HMIN = -(AW'(1) << (iirdf1_pkg::HIST_W - 1));
    localparam logic signed [AW-1:0] YMAX = (AW'(1) << (iirdf1_pkg::SAMPLE_W - 1)) - AW'(1);
    localparam logic signed [AW-1:0] YMIN = -(AW'(1) << (iirdf1_pkg::SAMPLE_W - 1));

    logic signed [AW-1:0] w_h_shift;
    logic signed [AW-1:0] w_y_shift;

    // round half up then floor
    assign w_h_shift = (i_acc + HALF_H) >>> iirdf1_pkg::SHIFT_H;
    assign w_y_shift = (i_acc + HALF_Y) >>> iirdf1_pkg::SHIFT_Y;

    always_comb begin
        if (w_h_shift > HMAX) begin
            o_hist = HMAX[iirdf1_pkg::HIST_W-1:0];
        end else if (w_h_shift < HMIN) begin
            o_hist = HMIN[iirdf1_pkg::HIST_W-1:0];
        end else begin
            o_hist = w_h_shift[iirdf1_pkg::HIST_W-1:0];
        end
        if (w_y_shift > YMAX) begin
            o_sample = YMAX[iirdf1_pkg::SAMPLE_W-1:0];
        end else if (w_y_shift < YMIN) begin
            o_sample = YMIN[iirdf1_pkg::SAMPLE_W-1:0];
        end else begin
            o_sample = w_y_shift[iirdf1_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

// File: design/iirdf1_ctrl.sv
module iirdf1_ctrl #(
    parameter int PW = 2,
    parameter int NW = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NW-1:0]          i_n,
    input  logic [PW-1:0]          i_pos,
    input  logic                   i_out_free,
    output logic                   o_ready,
    output iirdf1_pkg::t_seq_ctl   o_ctl,
    output logic [PW-1:0]          o_tap,
    output logic [PW-1:0]          o_slot
);

    iirdf1_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_tap, n_tap;
    logic [PW-1:0] r_slot, n_slot;
    logic [PW-1:0] w_last;
    logic          w_at_last;

    assign w_last    = PW'(i_n - NW'(1));
    assign w_at_last = (r_tap == w_last);

    function automatic logic [PW-1:0] prev_slot(input logic [PW-1:0] p,
                                                input logic [PW-1:0] last);
        return (p == '0) ? last : p - PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iirdf1_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_tap  <= n_tap;
        r_slot <= n_slot;
    end

    // next state and tap walk
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_slot  = r_slot;
        case (r_state)
            iirdf1_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = iirdf1_pkg::ST_FF;
                    n_tap   = '0;
                    n_slot  = i_pos;
                end
            end
            iirdf1_pkg::ST_FF: begin
                if (w_at_last) begin
                    if (w_last == '0) begin
                        n_state = iirdf1_pkg::ST_DRAIN;
                    end else begin
                        n_state = iirdf1_pkg::ST_FB;
                        n_tap   = PW'(1);
                        n_slot  = prev_slot(i_pos, w_last);
                    end
                end else begin
                    n_tap  = r_tap + PW'(1);
                    n_slot = prev_slot(r_slot, w_last);
                end
            end
            iirdf1_pkg::ST_FB: begin
                if (w_at_last) begin
                    n_state = iirdf1_pkg::ST_DRAIN;
                end else begin
                    n_tap  = r_tap + PW'(1);
                    n_slot = prev_slot(r_slot, w_last);
                end
            end
            iirdf1_pkg::ST_DRAIN: begin
                n_state = iirdf1_pkg::ST_ROUND;
            end
            iirdf1_pkg::ST_ROUND: begin
                if (i_out_free) begin
                    n_state = iirdf1_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iirdf1_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ready      = 1'b0;
        o_ctl.clear  = 1'b0;
        o_ctl.issue  = 1'b0;
        o_ctl.sel_fb = 1'b0;
        o_ctl.round  = 1'b0;
        case (r_state)
            iirdf1_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_ctl.clear = i_start;
            end
            iirdf1_pkg::ST_FF: begin
                o_ctl.issue = 1'b1;
            end
            iirdf1_pkg::ST_FB: begin
                o_ctl.issue  = 1'b1;
                o_ctl.sel_fb = 1'b1;
            end
            iirdf1_pkg::ST_ROUND: begin
                o_ctl.round = i_out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_tap  = r_tap;
    assign o_slot = r_slot;

endmodule

// File: design/iir_direct_form_one_filter.sv
// direct form I biquad over 16-bit signed samples, with Q4.14 coefficients
// (b0, b1, b2, a1, a2; leading feedback weight fixed at one) and a feedback
// history kept at 24 bits with 8 fraction bits. one multiplier is shared by
// every tap: a sample with T taps in use (1 to MAX_TAPS) issues 2T-1 products,
// one a cycle; a drain state lets the last product reach the accumulator, and
// a round state rounds, saturates and registers the result once the output
// register is free. the input is not ready while a sample is in flight; a
// finished sample waits in the output register, and the next one can be taken
// meanwhile. histories reset to zero at once, with no clearing pass. configuration
// is written by index over a separate channel that is always ready; the user
// must write it only while the filter is idle, which the block does not check.
module iir_direct_form_one_filter #(
    parameter int MAX_TAPS = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [15:0]                           s_axis_tdata,   // [15:0] sample_in
    // output sample stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [15:0]                           m_axis_tdata,   // [15:0] sample_out
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iirdf1_pkg::COEF_W-1:0]         i_cfg_data
);

    // ring slot and tap count widths follow the history depth
    localparam int PW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW = $clog2(MAX_TAPS + 1);

    // configuration registers
    logic [iirdf1_pkg::TAPS_W-1:0]        r_taps;
    logic signed [iirdf1_pkg::COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // sample histories, ring position and per-sample latches
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] r_xh [MAX_TAPS];
    logic signed [iirdf1_pkg::HIST_W-1:0]   r_yh [MAX_TAPS];
    logic [PW-1:0] r_ring;
    logic [PW-1:0] r_pos;
    logic [NW-1:0] r_n;

    // output register
    logic                                   r_out_valid;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] r_out;

    logic                                   w_s_accept;
    logic                                   w_out_free;
    logic [iirdf1_pkg::TAPS_W-1:0]          w_taps_min;
    logic [NW-1:0]                          w_n_eff;
    logic [PW-1:0]                          w_pos_eff;
    logic [PW-1:0]                          w_ring_next;
    iirdf1_pkg::t_seq_ctl                   w_ctl;
    logic [PW-1:0]                          w_tap;
    logic [PW-1:0]                          w_slot;
    logic signed [iirdf1_pkg::COEF_W-1:0]   w_coef;
    logic signed [iirdf1_pkg::OPND_W-1:0]   w_opnd;
    logic signed [iirdf1_pkg::ACC_W-1:0]    w_acc;
    logic signed [iirdf1_pkg::HIST_W-1:0]   w_hist;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] w_sample;

    assign o_cfg_ready = 1'b1;
    assign w_s_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // taps of zero act as one, anything above the depth as the depth
    assign w_taps_min = (r_taps == '0) ? iirdf1_pkg::TAPS_W'(1) : r_taps;
    assign w_n_eff = (32'(w_taps_min) > MAX_TAPS) ? NW'(MAX_TAPS) : NW'(w_taps_min);

    // a ring position left beyond the taps in use restarts at slot zero
    // (steady from the transaction until the round, so the sequencer reads it too)
    assign w_pos_eff = (32'(r_ring) >= 32'(w_n_eff)) ? '0 : r_ring;

    assign w_ring_next = (32'(r_pos) + 1 >= 32'(r_n)) ? '0 : r_pos + PW'(1);

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= iirdf1_pkg::TAPS_RESET;
            r_b0   <= iirdf1_pkg::B0_RESET;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                iirdf1_pkg::CFG_TAPS: r_taps <= i_cfg_data[iirdf1_pkg::TAPS_W-1:0];
                iirdf1_pkg::CFG_B0:   r_b0   <= i_cfg_data;
                iirdf1_pkg::CFG_B1:   r_b1   <= i_cfg_data;
                iirdf1_pkg::CFG_B2:   r_b2   <= i_cfg_data;
                iirdf1_pkg::CFG_A1:   r_a1   <= i_cfg_data;
                iirdf1_pkg::CFG_A2:   r_a2   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // histories: input slot written on the transaction, output slot on round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_xh[i] <= '0;
                r_yh[i] <= '0;
            end
            r_ring <= '0;
        end else begin
            if (w_s_accept) begin
                r_xh[w_pos_eff] <= s_axis_tdata;
            end
            if (w_ctl.round) begin
                r_yh[r_pos] <= w_hist;
                r_ring      <= w_ring_next;
            end
        end
    end

    // tap count and slot held for the whole sample
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_pos <= w_pos_eff;
            r_n   <= w_n_eff;
        end
    end

    // output register, freed by the downstream transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.round) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_ctl.round) begin
            r_out <= w_sample;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (int'(w_tap))
            0:       w_coef = w_ctl.sel_fb ? '0 : r_b0;
            1:       w_coef = w_ctl.sel_fb ? r_a1 : r_b1;
            2:       w_coef = w_ctl.sel_fb ? r_a2 : r_b2;
            default: w_coef = '0;
        endcase
    end

    // feedforward samples carry 8 extra fraction bits to line up with feedback
    assign w_opnd = w_ctl.sel_fb ? r_yh[w_slot]
                                 : {r_xh[w_slot], {iirdf1_pkg::X_SHIFT{1'b0}}};

    iirdf1_ctrl #(
        .PW       (PW),
        .NW       (NW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_s_accept),
        .i_n        (r_n),
        .i_pos      (w_pos_eff),
        .i_out_free (w_out_free),
        .o_ready    (s_axis_tready),
        .o_ctl      (w_ctl),
        .o_tap      (w_tap),
        .o_slot     (w_slot)
    );

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_ctl.clear),
        .i_issue (w_ctl.issue),
        .i_sub   (w_ctl.sel_fb),
        .i_coef  (w_coef),
        .i_opnd  (w_opnd),
        .o_acc   (w_acc)
    );

    iirdf1_round u_round (
        .i_acc    (w_acc),
        .o_hist   (w_hist),
        .o_sample (w_sample)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

// File: design/iirdf1_checker.sv
`include "iir_direct_form_one_filter_assert.svh"

module iirdf1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic w_s_accept;

    assign w_s_accept = s_axis_tvalid && s_axis_tready;

    // a stalled result stays put
    `IIRDF1_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    // the input stays closed after a sample is accepted
    `IIRDF1_ASSERT(a_busy_after_accept, w_s_accept |=> !s_axis_tready ##1 !s_axis_tready, "input reopened too early")

    // reset empties the output register
    `IIRDF1_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind iir_direct_form_one_filter iirdf1_checker u_iirdf1_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb_iir_direct_form_one_filter.sv
`timescale 1ns / 1ps

module tb_iir_direct_form_one_filter;

    localparam int MAX_TAPS    = 3;
    localparam int CYCLE_LIMIT = 400000;
    // settle time after the last output
    localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 10;

    // register indexes beyond the list, which the filter must ignore
    localparam logic [iirdf1_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [iirdf1_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam longint HIST_MAX = (longint'(1) <<< (iirdf1_pkg::HIST_W - 1)) - 1;
    localparam longint HIST_MIN = -(longint'(1) <<< (iirdf1_pkg::HIST_W - 1));
    localparam longint OUT_MAX  = 32767;
    localparam longint OUT_MIN  = -32768;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    // one row of the directed table: a register write or a sample, with an
    // optional hand-worked output
    typedef struct {
        t_row_kind                           kind;
        logic [iirdf1_pkg::CFG_IDX_W-1:0]    idx;
        logic [iirdf1_pkg::COEF_W-1:0]       val;
        logic signed [15:0]                  x;
        logic                                known;
        logic signed [15:0]                  want;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [15:0]             s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [15:0]             m_axis_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [iirdf1_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [iirdf1_pkg::COEF_W-1:0]    i_cfg_data = '0;

    // hand-worked expectation travelling alongside the sample on the bus
    logic                    known_flag = 1'b0;
    logic [15:0]             known_want = '0;

    // predictor copy of the filter: settings, histories and ring slot
    logic [iirdf1_pkg::TAPS_W-1:0]       taps_setting;
    logic signed [iirdf1_pkg::COEF_W-1:0] gain_b [0:2];
    logic signed [iirdf1_pkg::COEF_W-1:0] gain_a [0:2];
    logic signed [15:0]                  x_hist [0:2];
    logic signed [iirdf1_pkg::HIST_W-1:0] y_hist [0:2];
    int                      ring_pos;

    logic [15:0]             pending_outputs [$];
    t_row                    directed_rows [$];

    int                      mismatch_count = 0;
    int                      outputs_seen = 0;
    int                      cycle_count = 0;
    bit                      no_idle = 1'b0;
    int                      stall_left = 0;
    int                      stall_drawn_at = 0;
    logic [15:0]             mon_want;
    logic [15:0]             mon_pred;

    iir_direct_form_one_filter #(
        .MAX_TAPS (MAX_TAPS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] sample_in
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] sample_out
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // one fixed-point biquad step: writes the sample into the ring, sums the
    // feedforward and feedback products with 22 fraction bits, stores the
    // rounded 24-bit history value and returns the rounded 16-bit output
    function automatic logic [15:0] step_biquad(input logic signed [15:0] x);
        int     n;
        int     pos;
        int     idx;
        int     i;
        longint acc;
        longint h;
        longint y;
        n = int'(taps_setting);
        // zero taps behaves as a pure gain, more than the maximum is clipped
        if (n < 1) n = 1;
        if (n > MAX_TAPS) n = MAX_TAPS;
        // ring slot left out of range by a lowered tap count restarts at zero
        pos = ring_pos;
        if (pos >= n) pos = 0;
        x_hist[pos] = x;
        acc = 0;
        idx = (pos == 0) ? n - 1 : pos - 1;
        for (i = 1; i < n; i++) begin
            acc -= longint'(gain_a[i]) * longint'(y_hist[idx]);
            idx = (idx == 0) ? n - 1 : idx - 1;
        end
        idx = pos;
        for (i = 0; i < n; i++) begin
            acc += longint'(gain_b[i]) * longint'(x_hist[idx]) * 256;
            idx = (idx == 0) ? n - 1 : idx - 1;
        end
        // round half up by adding half then flooring
        h = (acc + (longint'(1) <<< (iirdf1_pkg::SHIFT_H - 1))) >>> iirdf1_pkg::SHIFT_H;
        if (h > HIST_MAX) h = HIST_MAX;
        if (h < HIST_MIN) h = HIST_MIN;
        y_hist[pos] = h[iirdf1_pkg::HIST_W-1:0];
        y = (acc + (longint'(1) <<< (iirdf1_pkg::SHIFT_Y - 1))) >>> iirdf1_pkg::SHIFT_Y;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        ring_pos = (pos + 1 >= n) ? 0 : pos + 1;
        return y[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("ERROR cycle %0d: %s got %0d want %0d", cycle_count, what,
                 $signed(got), $signed(want));
    endtask

    // output check, predictor update on each accepted sample and register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                outputs_seen++;
                if (pending_outputs.size() == 0) begin
                    report_mismatch("unexpected sample_out", m_axis_tdata, '0);
                end else begin
                    mon_want = pending_outputs.pop_front();
                    if (m_axis_tdata !== mon_want) begin
                        report_mismatch("sample_out", m_axis_tdata, mon_want);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                // the predictor runs for every sample so its histories stay in step
                mon_pred = step_biquad(s_axis_tdata);
                pending_outputs.push_back(known_flag ? known_want : mon_pred);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    iirdf1_pkg::CFG_TAPS:
                        taps_setting = i_cfg_data[iirdf1_pkg::TAPS_W-1:0];
                    iirdf1_pkg::CFG_B0:   gain_b[0] = i_cfg_data;
                    iirdf1_pkg::CFG_B1:   gain_b[1] = i_cfg_data;
                    iirdf1_pkg::CFG_B2:   gain_b[2] = i_cfg_data;
                    iirdf1_pkg::CFG_A1:   gain_a[1] = i_cfg_data;
                    iirdf1_pkg::CFG_A2:   gain_a[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // receiver: a fresh random stall after every output transaction, none in phases without idling
    always @(negedge i_clk) begin
        if (outputs_seen != stall_drawn_at) begin
            stall_drawn_at = outputs_seen;
            stall_left = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one sample after a random gap and hold it until the transaction
    task automatic push_sample(input logic [15:0] x, input logic known,
                               input logic [15:0] want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        known_flag    <= known;
        known_want    <= want;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering samples and wait until every pending output has arrived
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(negedge i_clk);
    endtask

    // register writes only once the filter has gone idle
    task automatic write_reg(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iirdf1_pkg::COEF_W-1:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_cfg_row(input logic [iirdf1_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [iirdf1_pkg::COEF_W-1:0] val);
        t_row r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.val   = val;
        r.x     = '0;
        r.known = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample_row(input logic signed [15:0] x, input logic known,
                                           input logic signed [15:0] want);
        t_row r;
        r.kind  = ROW_SAMPLE;
        r.idx   = '0;
        r.val   = '0;
        r.x     = x;
        r.known = known;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // coefficients: full range, moderate, the two extremes or zero
    function automatic logic [iirdf1_pkg::COEF_W-1:0] pick_coef();
        logic [iirdf1_pkg::COEF_W-1:0] v;
        case ($urandom_range(0, 7))
            0, 1, 2: v = iirdf1_pkg::COEF_W'($urandom());
            3, 4:    v = iirdf1_pkg::COEF_W'($urandom_range(0, 32768) - 16384);
            5:       v = 18'h1FFFF;
            6:       v = 18'h20000;
            default: v = '0;
        endcase
        return v;
    endfunction

    // samples: mostly full range, some extremes and some small values
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2:       v = 16'($urandom_range(0, 128) - 64);
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    initial begin
        int   r;
        int   phase;
        int   k;
        t_row row;

        // predictor at its reset state: three taps, unity b0, empty histories
        taps_setting = iirdf1_pkg::TAPS_RESET;
        for (r = 0; r < 3; r++) begin
            gain_b[r] = '0;
            gain_a[r] = '0;
            x_hist[r] = '0;
            y_hist[r] = '0;
        end
        gain_b[0] = iirdf1_pkg::B0_RESET;
        ring_pos  = 0;

        // after reset the filter passes samples straight through
        add_sample_row(16'sd0, 1'b1, 16'sd0);
        add_sample_row(16'sd32767, 1'b1, 16'sd32767);
        add_sample_row(-16'sd32768, 1'b1, -16'sd32768);
        add_sample_row(16'sd1, 1'b1, 16'sd1);
        add_sample_row(-16'sd1, 1'b1, -16'sd1);
        // largest gain saturates both ways
        add_cfg_row(iirdf1_pkg::CFG_B0, 18'h1FFFF);
        add_sample_row(16'sd32767, 1'b1, 16'sd32767);
        add_sample_row(-16'sd32768, 1'b1, -16'sd32768);
        // most negative gain flips and saturates
        add_cfg_row(iirdf1_pkg::CFG_B0, 18'h20000);
        add_sample_row(-16'sd32768, 1'b1, 16'sd32767);
        add_sample_row(16'sd32767, 1'b1, -16'sd32768);
        // writes beyond the register list leave b0 at minus eight
        add_cfg_row(CFG_UNUSED_LO, 18'h00000);
        add_cfg_row(CFG_UNUSED_HI, 18'h3FFFF);
        add_sample_row(16'sd100, 1'b1, -16'sd800);
        // three-tap moving sum, then with feedback
        add_cfg_row(iirdf1_pkg::CFG_B0, 18'sd16384);
        add_cfg_row(iirdf1_pkg::CFG_B1, 18'sd16384);
        add_cfg_row(iirdf1_pkg::CFG_B2, 18'sd16384);
        add_sample_row(16'sd1000, 1'b0, '0);
        add_sample_row(16'sd2000, 1'b0, '0);
        add_sample_row(-16'sd500, 1'b0, '0);
        add_cfg_row(iirdf1_pkg::CFG_A1, 18'sd8192);
        add_cfg_row(iirdf1_pkg::CFG_A2, -18'sd4096);
        add_sample_row(16'sd30000, 1'b0, '0);
        add_sample_row(-16'sd30000, 1'b0, '0);
        add_sample_row(16'sd12345, 1'b0, '0);
        // zero taps acts as one: pure unity gain
        add_cfg_row(iirdf1_pkg::CFG_TAPS, 18'd0);
        add_sample_row(16'sd1234, 1'b1, 16'sd1234);
        add_cfg_row(iirdf1_pkg::CFG_TAPS, 18'd2);
        add_sample_row(16'sd700, 1'b0, '0);
        add_sample_row(-16'sd700, 1'b0, '0);
        // leave the ring at slot two, then lower the taps so it restarts
        add_cfg_row(iirdf1_pkg::CFG_TAPS, 18'd3);
        add_sample_row(16'sd5000, 1'b0, '0);
        add_sample_row(-16'sd5000, 1'b0, '0);
        add_cfg_row(iirdf1_pkg::CFG_TAPS, 18'd2);
        add_sample_row(16'sd321, 1'b0, '0);
        // half gain on one tap: rounding of halves goes upwards
        add_cfg_row(iirdf1_pkg::CFG_TAPS, 18'd1);
        add_cfg_row(iirdf1_pkg::CFG_B0, 18'sd8192);
        add_sample_row(16'sd3, 1'b1, 16'sd2);
        add_sample_row(-16'sd3, 1'b1, -16'sd1);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG) begin
                write_reg(row.idx, row.val);
            end else begin
                push_sample(row.x, row.known, row.want);
            end
        end

        // random phases: every register rewritten, tap count cycling through
        // all four codes, some phases without any idling
        for (phase = 0; phase < 13; phase++) begin
            no_idle = (phase % 4 == 2);
            write_reg(iirdf1_pkg::CFG_TAPS,
                      {16'($urandom_range(0, 65535)), 2'(phase % 4)});
            write_reg(iirdf1_pkg::CFG_B0, pick_coef());
            write_reg(iirdf1_pkg::CFG_B1, pick_coef());
            write_reg(iirdf1_pkg::CFG_B2, pick_coef());
            write_reg(iirdf1_pkg::CFG_A1, pick_coef());
            write_reg(iirdf1_pkg::CFG_A2, pick_coef());
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                          iirdf1_pkg::COEF_W'($urandom()));
            end
            for (k = 0; k < 110; k++) begin
                // now and then hold the input off until the filter has emptied
                if (k == 55 && phase % 3 == 0) drain_results();
                push_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
